/* hdl/mscb_pkg.sv */
// ----------------------------------------------------------------------------
// mscb_pkg
// Shared types and constants for the multichannel sample capture buffer.
// ----------------------------------------------------------------------------
package mscb_pkg;

    localparam int DATA_W        = 16;
    localparam int CH_FIELD_W    = 8;
    localparam int SAMPLE_INPUTS = 6;
    localparam int FULL_BITS     = 6;

    typedef enum logic [1:0] {
        REQ_TICK     = 2'd0,
        REQ_SET_SIZE = 2'd1,
        REQ_REARM    = 2'd2,
        REQ_READ     = 2'd3
    } req_t;

    typedef enum logic [1:0] {
        STAT_OK           = 2'd0,
        STAT_BAD_CHANNEL  = 2'd1,
        STAT_TOO_LARGE    = 2'd2,
        STAT_NOT_CAPTURED = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_TICK,
        ST_SET_LOAD,
        ST_SET_SUM,
        ST_SET_CHECK,
        ST_REBASE,
        ST_READ_CHECK,
        ST_READ_WAIT,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic accept;
        logic idx_zero;
        logic idx_ch;
        logic idx_inc;
        logic acc_zero;
        logic tick_step;
        logic size_load_new;
        logic size_restore;
        logic sum_step;
        logic rebase_step;
        logic stat_bad_channel;
        logic stat_too_large;
        logic stat_not_captured;
        logic mem_rd;
        logic rd_capture;
        logic out_load;
    } dp_cmd_t;

    typedef struct packed {
        logic ch_ok;
        logic idx_last;
        logic over;
        logic beyond;
        logic out_free;
    } dp_status_t;

endpackage

/* hdl/mscb_ctrl.sv */
// ----------------------------------------------------------------------------
// mscb_ctrl
// Request sequencer: walks the channel table for ticks, size changes and
// re-basing, checks reads, and hands the result to the output register.
// ----------------------------------------------------------------------------
module mscb_ctrl
    import mscb_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       in_valid,
    input  req_t       in_req,
    output logic       in_ready,
    input  dp_status_t dp_status,
    output dp_cmd_t    dp_cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        dp_cmd     = '0;
        in_ready   = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    dp_cmd.accept   = 1'b1;
                    dp_cmd.acc_zero = 1'b1;
                    case (in_req)
                        REQ_TICK: begin
                            dp_cmd.idx_zero = 1'b1;
                            state_next      = ST_TICK;
                        end
                        REQ_SET_SIZE: state_next = ST_SET_LOAD;
                        REQ_REARM: begin
                            dp_cmd.idx_zero = 1'b1;
                            state_next      = ST_REBASE;
                        end
                        REQ_READ: state_next = ST_READ_CHECK;
                        default: state_next = ST_IDLE;
                    endcase
                end
            end
            ST_TICK: begin
                dp_cmd.tick_step = 1'b1;
                if (dp_status.idx_last) begin
                    dp_cmd.idx_ch = 1'b1;
                    state_next    = ST_FINISH;
                end else begin
                    dp_cmd.idx_inc = 1'b1;
                end
            end
            ST_SET_LOAD: begin
                if (!dp_status.ch_ok) begin
                    dp_cmd.stat_bad_channel = 1'b1;
                    state_next              = ST_FINISH;
                end else begin
                    dp_cmd.size_load_new = 1'b1;
                    dp_cmd.idx_zero      = 1'b1;
                    state_next           = ST_SET_SUM;
                end
            end
            ST_SET_SUM: begin
                dp_cmd.sum_step = 1'b1;
                if (dp_status.idx_last) begin
                    dp_cmd.idx_ch = 1'b1;
                    state_next    = ST_SET_CHECK;
                end else begin
                    dp_cmd.idx_inc = 1'b1;
                end
            end
            ST_SET_CHECK: begin
                if (dp_status.over) begin
                    dp_cmd.size_restore   = 1'b1;
                    dp_cmd.stat_too_large = 1'b1;
                end
                dp_cmd.idx_zero = 1'b1;
                dp_cmd.acc_zero = 1'b1;
                state_next      = ST_REBASE;
            end
            ST_REBASE: begin
                dp_cmd.rebase_step = 1'b1;
                if (dp_status.idx_last) begin
                    dp_cmd.idx_ch = 1'b1;
                    state_next    = ST_FINISH;
                end else begin
                    dp_cmd.idx_inc = 1'b1;
                end
            end
            ST_READ_CHECK: begin
                if (!dp_status.ch_ok) begin
                    dp_cmd.stat_bad_channel = 1'b1;
                    state_next              = ST_FINISH;
                end else if (dp_status.beyond) begin
                    dp_cmd.stat_not_captured = 1'b1;
                    state_next               = ST_FINISH;
                end else begin
                    dp_cmd.mem_rd = 1'b1;
                    state_next    = ST_READ_WAIT;
                end
            end
            ST_READ_WAIT: begin
                dp_cmd.rd_capture = 1'b1;
                state_next        = ST_FINISH;
            end
            ST_FINISH: begin
                if (dp_status.out_free) begin
                    dp_cmd.out_load = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

endmodule

/* hdl/mscb_datapath.sv */
// ----------------------------------------------------------------------------
// mscb_datapath
// Channel tables, shared sample memory, running-sum accumulator and the
// result register.
// ----------------------------------------------------------------------------
module mscb_datapath
    import mscb_pkg::*;
#(
    parameter int CHANNELS  = 6,
    parameter int RAM_WORDS = 8192
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  dp_cmd_t                      dp_cmd,
    output dp_status_t                   dp_status,
    input  logic [CH_FIELD_W-1:0]        in_channel,
    input  logic [DATA_W-1:0]            in_new_size,
    input  logic [DATA_W-1:0]            in_word_index,
    input  logic [SAMPLE_INPUTS-1:0][DATA_W-1:0] in_samples,
    input  logic                         out_ready,
    output logic                         out_valid,
    output status_t                      out_status,
    output logic [DATA_W-1:0]            out_read_data,
    output logic [DATA_W-1:0]            out_count,
    output logic [FULL_BITS-1:0]         out_full
);

    localparam int CH_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int ADDR_W = $clog2(RAM_WORDS);
    localparam int BASE_W = $clog2(RAM_WORDS + 1);
    localparam int SUM_W  = $clog2(RAM_WORDS + 65536);
    localparam int AS_W   = DATA_W + 1;

    logic [DATA_W-1:0] size_reg [CHANNELS];
    logic [BASE_W-1:0] base_reg [CHANNELS];
    logic [DATA_W-1:0] fill_reg [CHANNELS];
    logic [DATA_W-1:0] mem [RAM_WORDS];

    logic [CH_W-1:0]       idx_reg;
    logic [CH_W-1:0]       idx_next;
    logic [SUM_W-1:0]      acc_reg;
    logic [SUM_W-1:0]      acc_next;
    logic [CH_FIELD_W-1:0] channel_reg;
    logic [DATA_W-1:0]     new_size_reg;
    logic [DATA_W-1:0]     word_index_reg;
    logic [DATA_W-1:0]     old_size_reg;
    logic [SAMPLE_INPUTS-1:0][DATA_W-1:0] samples_reg;
    status_t               status_reg;
    logic [DATA_W-1:0]     rdata_reg;
    logic [DATA_W-1:0]     mem_q_reg;

    logic                  m_valid_reg;
    status_t               m_status_reg;
    logic [DATA_W-1:0]     m_data_reg;
    logic [DATA_W-1:0]     m_count_reg;
    logic [FULL_BITS-1:0]  m_full_reg;

    logic [DATA_W-1:0]     cur_size;
    logic [BASE_W-1:0]     cur_base;
    logic [DATA_W-1:0]     cur_fill;
    logic                  ch_ok;
    logic                  can_store;
    logic [AS_W-1:0]       wr_sum;
    logic [AS_W-1:0]       rd_sum;
    logic [DATA_W-1:0]     tick_sample;
    logic [FULL_BITS-1:0]  full_now;

    assign cur_size  = size_reg[idx_reg];
    assign cur_base  = base_reg[idx_reg];
    assign cur_fill  = fill_reg[idx_reg];
    assign ch_ok     = channel_reg < CH_FIELD_W'(CHANNELS);
    assign can_store = cur_fill < cur_size;
    assign wr_sum    = AS_W'(cur_base) + AS_W'(cur_fill);
    assign rd_sum    = AS_W'(cur_base) + AS_W'(word_index_reg);

    always_comb begin
        tick_sample = '0;
        for (int k = 0; k < CHANNELS; k++) begin
            if (k < SAMPLE_INPUTS && idx_reg == CH_W'(k)) begin
                tick_sample = samples_reg[k];
            end
        end
    end

    always_comb begin
        full_now = '0;
        for (int k = 0; k < FULL_BITS; k++) begin
            if (k < CHANNELS) begin
                full_now[k] = fill_reg[k] >= size_reg[k];
            end
        end
    end

    assign dp_status.ch_ok    = ch_ok;
    assign dp_status.idx_last = idx_reg == CH_W'(CHANNELS - 1);
    assign dp_status.over     = acc_reg > SUM_W'(RAM_WORDS);
    assign dp_status.beyond   = word_index_reg >= cur_fill;
    assign dp_status.out_free = !m_valid_reg || out_ready;

    always_comb begin
        idx_next = idx_reg;
        if (dp_cmd.idx_zero) begin
            idx_next = '0;
        end else if (dp_cmd.accept) begin
            idx_next = in_channel[CH_W-1:0];
        end else if (dp_cmd.idx_ch) begin
            idx_next = channel_reg[CH_W-1:0];
        end else if (dp_cmd.idx_inc) begin
            idx_next = CH_W'(idx_reg + 1'b1);
        end
    end

    always_comb begin
        acc_next = acc_reg;
        if (dp_cmd.acc_zero) begin
            acc_next = '0;
        end else if (dp_cmd.sum_step || dp_cmd.rebase_step) begin
            acc_next = acc_reg + SUM_W'(cur_size);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg <= '0;
            acc_reg <= '0;
            for (int k = 0; k < CHANNELS; k++) begin
                size_reg[k] <= '0;
                base_reg[k] <= '0;
                fill_reg[k] <= '0;
            end
        end else begin
            idx_reg <= idx_next;
            acc_reg <= acc_next;
            if (dp_cmd.tick_step && can_store) begin
                fill_reg[idx_reg] <= DATA_W'(cur_fill + 1'b1);
            end
            if (dp_cmd.size_load_new) begin
                size_reg[idx_reg] <= new_size_reg;
            end
            if (dp_cmd.size_restore) begin
                size_reg[idx_reg] <= old_size_reg;
            end
            if (dp_cmd.rebase_step) begin
                base_reg[idx_reg] <= acc_reg[BASE_W-1:0];
                fill_reg[idx_reg] <= '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (dp_cmd.accept) begin
            channel_reg    <= in_channel;
            new_size_reg   <= in_new_size;
            word_index_reg <= in_word_index;
            samples_reg    <= in_samples;
        end
        if (dp_cmd.size_load_new) begin
            old_size_reg <= cur_size;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            status_reg <= STAT_OK;
            rdata_reg  <= '0;
        end else begin
            if (dp_cmd.accept) begin
                status_reg <= STAT_OK;
                rdata_reg  <= '0;
            end
            if (dp_cmd.stat_bad_channel) begin
                status_reg <= STAT_BAD_CHANNEL;
            end
            if (dp_cmd.stat_too_large) begin
                status_reg <= STAT_TOO_LARGE;
            end
            if (dp_cmd.stat_not_captured) begin
                status_reg <= STAT_NOT_CAPTURED;
            end
            if (dp_cmd.rd_capture) begin
                rdata_reg <= mem_q_reg;
            end
        end
    end

    // sample memory: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (dp_cmd.tick_step && can_store) begin
            mem[wr_sum[ADDR_W-1:0]] <= tick_sample;
        end
        if (dp_cmd.mem_rd) begin
            mem_q_reg <= mem[rd_sum[ADDR_W-1:0]];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (dp_cmd.out_load) begin
            m_valid_reg <= 1'b1;
        end else if (out_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (dp_cmd.out_load) begin
            m_status_reg <= status_reg;
            m_data_reg   <= rdata_reg;
            m_count_reg  <= ch_ok ? cur_fill : '0;
            m_full_reg   <= full_now;
        end
    end

    assign out_valid     = m_valid_reg;
    assign out_status    = m_status_reg;
    assign out_read_data = m_data_reg;
    assign out_count     = m_count_reg;
    assign out_full      = m_full_reg;

endmodule

/* hdl/multichannel_sample_capture_buffer.sv */
// Takes one request transaction at a time and returns exactly one result
// transaction for it. The channel table is walked one channel per cycle through
// a single table port and the one write port of the sample memory. A set-size
// request makes a summing pass, then a re-basing pass. A new request is taken
// while the previous result still waits in the output register.
// ----------------------------------------------------------------------------
// multichannel_sample_capture_buffer
// Shared sample memory split into back-to-back per-channel capture regions.
// ----------------------------------------------------------------------------
module multichannel_sample_capture_buffer
    import mscb_pkg::*;
#(
    parameter int CHANNELS  = 6,
    parameter int RAM_WORDS = 8192
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // channel, new_size, word_index, sample_0 .. sample_5
    input  logic [135:0] s_tdata,
    // req_type
    input  logic [1:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // read_data, captured_count, full_mask, zero padding
    output logic [39:0]  m_tdata,
    // status
    output logic [1:0]   m_tuser
);

    dp_cmd_t    dp_cmd;
    dp_status_t dp_status;
    status_t    out_status;
    logic [DATA_W-1:0]    out_read_data;
    logic [DATA_W-1:0]    out_count;
    logic [FULL_BITS-1:0] out_full;
    logic [SAMPLE_INPUTS-1:0][DATA_W-1:0] samples;

    always_comb begin
        for (int k = 0; k < SAMPLE_INPUTS; k++) begin
            samples[k] = s_tdata[40 + k * DATA_W +: DATA_W];
        end
    end

    mscb_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_req    (req_t'(s_tuser)),
        .in_ready  (s_tready),
        .dp_status (dp_status),
        .dp_cmd    (dp_cmd)
    );

    mscb_datapath #(
        .CHANNELS  (CHANNELS),
        .RAM_WORDS (RAM_WORDS)
    ) u_datapath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .dp_cmd        (dp_cmd),
        .dp_status     (dp_status),
        .in_channel    (s_tdata[7:0]),
        .in_new_size   (s_tdata[23:8]),
        .in_word_index (s_tdata[39:24]),
        .in_samples    (samples),
        .out_ready     (m_tready),
        .out_valid     (m_tvalid),
        .out_status    (out_status),
        .out_read_data (out_read_data),
        .out_count     (out_count),
        .out_full      (out_full)
    );

    assign m_tdata = {2'b00, out_full, out_count, out_read_data};
    assign m_tuser = out_status;

`ifndef NO_ASSERTIONS
    a_busy_after_accept: assert property (
        @(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready
    ) else $error("request accepted while previous one still in progress");

    a_err_no_data: assert property (
        @(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser != STAT_OK) |-> m_tdata[15:0] == 16'd0
    ) else $error("read data nonzero on failed request");

    a_bad_ch_count: assert property (
        @(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == STAT_BAD_CHANNEL) |-> m_tdata[31:16] == 16'd0
    ) else $error("captured count nonzero for bad channel");
`endif

endmodule

/* test/multichannel_sample_capture_buffer_tb.sv */
// ----------------------------------------------------------------------------
// multichannel_sample_capture_buffer_tb
// Self-checking bench for the capture buffer. A short directed pass covers
// reset state, bad channels, capacity limits, zero-size regions and readback
// of extreme samples; random request streams then resize, fill, rearm and
// read back the regions. Typed directed rows carry their expected result; an internal
// model of the region table and sample memory predicts the rest, checked in order.
// ----------------------------------------------------------------------------
module multichannel_sample_capture_buffer_tb
    import mscb_pkg::*;
();

    localparam int NCH        = 6;
    localparam int MEM_WORDS  = 8192;
    localparam int RAND_ITEMS = 624;
    localparam int IDLE_LIMIT = 4000;

    typedef struct packed {
        req_t        req;
        logic [7:0]  ch;
        logic [15:0] size;
        logic [15:0] widx;
        logic [95:0] smp;   // sample_0 in the lowest bits
    } capture_req_t;

    typedef struct packed {
        status_t     st;
        logic [15:0] data;
        logic [15:0] cnt;
        logic [5:0]  mask;
    } capture_result_t;

    logic         aclk     = 1'b0;
    logic         aresetn  = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [135:0] s_tdata  = '0;
    logic [1:0]   s_tuser  = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [39:0]  m_tdata;
    logic [1:0]   m_tuser;

    int region_len  [NCH];
    int region_start[NCH];
    int fill_level  [NCH];
    logic [15:0] capture_mem [MEM_WORDS];

    capture_result_t expected_results[$];
    capture_req_t    dir_items[$];
    capture_result_t dir_want[$];
    bit              dir_typed[$];

    int errors = 0;
    int idle_cycles = 0;
    int burst_left = 0;
    int n_tick = 0, n_set = 0, n_rearm = 0, n_read = 0;
    int n_read_hit = 0, n_too_large = 0, n_bad_ch = 0, n_checked = 0;

    int      ready_mode = 0;
    int      ready_mode_left = 0;
    int      ready_phase = 0;

    multichannel_sample_capture_buffer i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial begin
        forever #1 aclk = ~aclk;
    end

    function automatic void rebase_regions();
        int k;
        int acc;
        acc = 0;
        for (k = 0; k < NCH; k++) begin
            region_start[k] = acc;
            fill_level[k]   = 0;
            acc += region_len[k];
        end
    endfunction

    function automatic capture_result_t apply_request(capture_req_t it);
        capture_result_t r;
        int  k;
        int  total;
        int  prev;
        int  addr;
        bit  ch_ok;
        r     = '0;
        r.st  = STAT_OK;
        ch_ok = (it.ch < NCH);
        case (it.req)
            REQ_TICK: begin
                for (k = 0; k < NCH; k++) begin
                    if (fill_level[k] < region_len[k]) begin
                        addr = region_start[k] + fill_level[k];
                        if (addr < MEM_WORDS)
                            capture_mem[addr] = it.smp[k*16 +: 16];
                        fill_level[k]++;
                    end
                end
            end
            REQ_SET_SIZE: begin
                if (!ch_ok) begin
                    r.st = STAT_BAD_CHANNEL;
                end else begin
                    prev = region_len[it.ch];
                    region_len[it.ch] = int'(it.size);
                    total = 0;
                    for (k = 0; k < NCH; k++)
                        total += region_len[k];
                    if (total > MEM_WORDS) begin
                        region_len[it.ch] = prev;
                        r.st = STAT_TOO_LARGE;
                    end
                    rebase_regions();
                end
            end
            REQ_REARM: begin
                rebase_regions();
            end
            default: begin
                if (!ch_ok) begin
                    r.st = STAT_BAD_CHANNEL;
                end else if (it.widx >= fill_level[it.ch]) begin
                    r.st = STAT_NOT_CAPTURED;
                end else begin
                    addr = region_start[it.ch] + it.widx;
                    if (addr < MEM_WORDS)
                        r.data = capture_mem[addr];
                end
            end
        endcase
        r.cnt = ch_ok ? fill_level[it.ch][15:0] : 16'd0;
        for (k = 0; k < NCH; k++)
            r.mask[k] = (fill_level[k] >= region_len[k]);
        return r;
    endfunction

    function automatic capture_req_t random_request();
        capture_req_t it;
        int pick;
        int k;
        int total;
        it.smp  = {$urandom, $urandom, $urandom};
        it.ch   = 8'($urandom_range(0, NCH - 1));
        it.size = 16'($urandom);
        it.widx = 16'($urandom);
        pick    = $urandom_range(0, 99);
        if (pick < 40) begin
            it.req = REQ_TICK;
        end else if (pick < 75) begin
            it.req = REQ_READ;
            if ($urandom_range(0, 9) == 0)
                it.ch = 8'($urandom_range(0, 255));
            else if ($urandom_range(0, 9) != 0)
                it.widx = 16'($urandom_range(0, fill_level[it.ch] + 1));
        end else if (pick < 93) begin
            it.req = REQ_SET_SIZE;
            case ($urandom_range(0, 19))
                0: it.ch = 8'($urandom_range(0, 255));
                1: ;
                2: begin
                    total = 0;
                    for (k = 0; k < NCH; k++)
                        total += region_len[k];
                    it.size = 16'(MEM_WORDS - (total - region_len[it.ch]));
                end
                default: it.size = 16'($urandom_range(0, 24));
            endcase
        end else begin
            it.req = REQ_REARM;
        end
        return it;
    endfunction

    function automatic void add_row(req_t req, int ch, int size, int widx, logic [15:0] smp,
                                    bit typed, status_t st, int cnt, int mask);
        capture_req_t    it;
        capture_result_t r;
        it.req  = req;
        it.ch   = 8'(ch);
        it.size = 16'(size);
        it.widx = 16'(widx);
        it.smp  = {6{smp}};
        r       = '0;
        r.st    = st;
        r.cnt   = 16'(cnt);
        r.mask  = 6'(mask);
        dir_items.push_back(it);
        dir_want.push_back(r);
        dir_typed.push_back(typed);
    endfunction

    task automatic send_request(capture_req_t it, bit typed, capture_result_t typed_res);
        capture_result_t r;
        int gap;
        s_tvalid <= 1'b1;
        s_tuser  <= it.req;
        s_tdata  <= {it.smp, it.widx, it.size, it.ch};
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        r = apply_request(it);
        expected_results.push_back(typed ? typed_res : r);
        case (it.req)
            REQ_TICK:     n_tick++;
            REQ_SET_SIZE: n_set++;
            REQ_REARM:    n_rearm++;
            default:      n_read++;
        endcase
        if (it.req == REQ_READ && r.st == STAT_OK)
            n_read_hit++;
        if (r.st == STAT_TOO_LARGE)
            n_too_large++;
        if (r.st == STAT_BAD_CHANNEL)
            n_bad_ch++;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            gap = $urandom_range(1, 12);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
            burst_left = $urandom_range(0, 40);
        end
    endtask

    task automatic wait_drained();
        while (expected_results.size() != 0)
            @(posedge aclk);
    endtask

    // receiver backpressure: full speed, random, or one beat in four
    always @(posedge aclk) begin
        if (ready_mode_left == 0) begin
            ready_mode      = $urandom_range(0, 2);
            ready_mode_left = $urandom_range(32, 256);
        end else begin
            ready_mode_left--;
        end
        ready_phase = (ready_phase + 1) % 4;
        case (ready_mode)
            0:       m_tready <= 1'b1;
            1:       m_tready <= 1'($urandom_range(0, 1));
            default: m_tready <= (ready_phase == 0);
        endcase
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    task automatic check_field(string name, int want, int got);
        if (want != got) begin
            errors++;
            $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
        end
    endtask

    always @(posedge aclk) begin : result_check
        capture_result_t got;
        capture_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = {status_t'(m_tuser), m_tdata[15:0], m_tdata[31:16], m_tdata[37:32]};
            if (expected_results.size() == 0) begin
                errors++;
                $display("%0t: unexpected result transaction, expected none, actual %p",
                         $time, got);
            end else begin
                want = expected_results.pop_front();
                n_checked++;
                check_field("status", int'(want.st), int'(got.st));
                check_field("read_data", int'(want.data), int'(got.data));
                check_field("captured_count", int'(want.cnt), int'(got.cnt));
                check_field("full_mask", int'(want.mask), int'(got.mask));
            end
        end
    end

    initial begin
        wait (idle_cycles >= IDLE_LIMIT);
        $display("%0t: timeout, %0d results outstanding", $time, expected_results.size());
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin : stimulus
        int i;
        int k;
        for (k = 0; k < NCH; k++)
            region_len[k] = 0;
        rebase_regions();

        //      request       ch   size    widx    sample  typed status  cnt mask
        add_row(REQ_READ,     0,   0,      0,      16'h0,    1, STAT_NOT_CAPTURED, 0, 'h3F);
        add_row(REQ_READ,     255, 0,      'hFFFF, 16'h0,    1, STAT_BAD_CHANNEL,  0, 'h3F);
        add_row(REQ_SET_SIZE, 6,   5,      0,      16'h0,    1, STAT_BAD_CHANNEL,  0, 'h3F);
        add_row(REQ_TICK,     0,   0,      0,      16'hFFFF, 1, STAT_OK,           0, 'h3F);
        add_row(REQ_SET_SIZE, 0,   'hFFFF, 0,      16'h0,    1, STAT_TOO_LARGE,    0, 'h3F);
        add_row(REQ_SET_SIZE, 0,   8192,   0,      16'h0,    1, STAT_OK,           0, 'h3E);
        add_row(REQ_SET_SIZE, 1,   1,      0,      16'h0,    1, STAT_TOO_LARGE,    0, 'h3E);
        add_row(REQ_SET_SIZE, 0,   0,      0,      16'h0,    1, STAT_OK,           0, 'h3F);
        add_row(REQ_SET_SIZE, 0,   3,      0,      16'h0,    0, STAT_OK, 0, 0);
        add_row(REQ_SET_SIZE, 1,   1,      0,      16'h0,    0, STAT_OK, 0, 0);
        add_row(REQ_SET_SIZE, 5,   2,      0,      16'h0,    0, STAT_OK, 0, 0);
        add_row(REQ_TICK,     0,   0,      0,      16'hFFFF, 0, STAT_OK, 0, 0);
        add_row(REQ_TICK,     5,   0,      0,      16'h0000, 0, STAT_OK, 0, 0);
        add_row(REQ_READ,     0,   0,      0,      16'h0,    0, STAT_OK, 0, 0);
        add_row(REQ_READ,     0,   0,      1,      16'h0,    0, STAT_OK, 0, 0);
        add_row(REQ_READ,     0,   0,      2,      16'h0,    0, STAT_OK, 0, 0);
        add_row(REQ_TICK,     1,   0,      0,      16'hA5A5, 0, STAT_OK, 0, 0);
        add_row(REQ_TICK,     0,   0,      0,      16'h5A5A, 0, STAT_OK, 0, 0);
        add_row(REQ_READ,     0,   0,      2,      16'h0,    0, STAT_OK, 0, 0);
        add_row(REQ_READ,     5,   0,      1,      16'h0,    0, STAT_OK, 0, 0);
        add_row(REQ_READ,     1,   0,      0,      16'h0,    0, STAT_OK, 0, 0);
        add_row(REQ_REARM,    0,   0,      0,      16'h0,    0, STAT_OK, 0, 0);
        add_row(REQ_READ,     0,   0,      0,      16'h0,    0, STAT_OK, 0, 0);
        add_row(REQ_SET_SIZE, 2,   8186,   0,      16'h0,    0, STAT_OK, 0, 0);
        add_row(REQ_SET_SIZE, 3,   1,      0,      16'h0,    0, STAT_OK, 0, 0);
        add_row(REQ_SET_SIZE, 2,   4,      0,      16'h0,    0, STAT_OK, 0, 0);

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        for (i = 0; i < dir_items.size(); i++)
            send_request(dir_items[i], dir_typed[i], dir_want[i]);

        for (i = 0; i < RAND_ITEMS; i++) begin
            if (i == RAND_ITEMS / 2) begin
                // hold off until the pipeline is empty
                s_tvalid <= 1'b0;
                wait_drained();
                @(posedge aclk);
            end
            send_request(random_request(), 1'b0, '0);
        end
        s_tvalid <= 1'b0;

        wait_drained();
        repeat (40) @(posedge aclk);

        $display("Sent %0d ticks, %0d set-size, %0d rearm, %0d reads (%0d hits)",
                 n_tick, n_set, n_rearm, n_read, n_read_hit);
        $display("Checked %0d results; rejected %0d over capacity, %0d bad channel",
                 n_checked, n_too_large, n_bad_ch);
        if (errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
